@@ sv/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Operation codes and the control group between the sequencer and divider.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_RED  = 3'd4;
    localparam logic [2:0] OP_ABS  = 3'd5;
    localparam logic [2:0] OP_CMP  = 3'd6;
    localparam logic [2:0] OP_NONE = 3'd7;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } rau_div_ctl_t;

endpackage

@@ sv/rational_arith_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arith_unit
// Fraction ALU reducing results by Euclid's gcd on one shared serial divider.
// ----------------------------------------------------------------------------
// Sequence from input accept to m_tvalid: abs and unused codes go from the multiply
// state straight to output, compare runs its multiply steps; arithmetic ops run
// their multiply steps, Euclid steps on the serial divider and a gcd check, then,
// unless the gcd is zero, divide numerator and denominator by the gcd before output.
// Throughput: one transaction at a time; s_tready is low until the result is taken.
// Reset: rst_n asynchronous, active low, returns the sequencer to idle.
module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[31:0], res_den[63:32], greater[64], less[65], equal[66],
    // div_error[67]
    output logic [71:0]  m_tdata
);
    import rau_pkg::*;

    localparam int W = WORD_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_GCD  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_QN   = 3'd4;
    localparam logic [2:0] ST_QD   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]   state_reg;
    logic [1:0]   step_reg;
    logic         waitq_reg;
    logic [2:0]   op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] p_reg;
    logic [W-1:0] x_reg, y_reg, n_reg, d_reg;
    logic [W-1:0] mul_a, mul_b, mul_p;
    logic         dstart;
    logic [W-1:0] ddvd, ddvs, dquo, drem;
    rau_div_ctl_t dctl;
    logic [31:0]  rn_reg, rd_reg;
    logic         gt_reg, lt_reg, eq_reg, err_reg;
    logic         ov_reg;

    function automatic logic [W-1:0] in_w(input logic [31:0] v);
        logic [63:0] e;
        e = {{32{v[31]}}, v};
        return e[W-1:0];
    endfunction

    function automatic logic [31:0] out_w(input logic [W-1:0] v);
        logic [63:0] e;
        e = {{(64-W){v[W-1]}}, v};
        return e[31:0];
    endfunction

    function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
        if (!v[W-1])
            return v;
        if (v == {1'b1, {(W-1){1'b0}}})
            return {1'b0, {(W-1){1'b1}}};
        return ~v + 1'b1;
    endfunction

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (step_reg)
            2'd0:    begin mul_a = (op_reg == OP_MUL) ? an_reg : an_reg;
                           mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg; end
            2'd1:    begin mul_a = ad_reg;
                           mul_b = (op_reg == OP_MUL) ? bd_reg : bn_reg; end
            2'd2:    begin mul_a = ad_reg; mul_b = bd_reg; end
            default: begin mul_a = ad_reg; mul_b = bd_reg; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        dstart = 1'b0;
        ddvd   = x_reg;
        ddvs   = y_reg;
        if (state_reg == ST_GCD && !waitq_reg && y_reg != '0)
            dstart = 1'b1;
        else if (state_reg == ST_QN && !waitq_reg)
        begin
            dstart = 1'b1;
            ddvd   = n_reg;
        end
        else if (state_reg == ST_QD && !waitq_reg)
        begin
            dstart = 1'b1;
            ddvd   = d_reg;
        end
    end

    rau_divider #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dstart),
        .dividend  (ddvd),
        .divisor   (ddvs),
        .ctl       (dctl),
        .quotient  (dquo),
        .remainder (drem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            waitq_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        step_reg  <= '0;
                        waitq_reg <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (op_reg == OP_ABS || op_reg == OP_NONE || op_reg == OP_RED)
                        state_reg <= (op_reg == OP_RED) ? ST_GCD : ST_OUT;
                    else if (step_reg == 2'd1 && op_reg == OP_CMP)
                        state_reg <= ST_OUT;
                    else if (step_reg == 2'd2 || (step_reg == 2'd1 &&
                             (op_reg == OP_MUL || op_reg == OP_DIV)))
                        state_reg <= ST_GCD;
                end
                ST_GCD:
                begin
                    if (waitq_reg)
                    begin
                        if (dctl.done)
                            waitq_reg <= 1'b0;
                    end
                    else if (y_reg == '0)
                        state_reg <= (x_reg == '0) ? ST_OUT : ST_QN;
                    else
                        waitq_reg <= 1'b1;
                end
                ST_QN, ST_QD:
                begin
                    if (waitq_reg)
                    begin
                        if (dctl.done)
                        begin
                            waitq_reg <= 1'b0;
                            state_reg <= (state_reg == ST_QN) ? ST_QD : ST_OUT;
                        end
                    end
                    else
                        waitq_reg <= 1'b1;
                end
                ST_OUT:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (m_tready)
                    begin
                        ov_reg    <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg  <= s_tdata[2:0];
                an_reg  <= in_w(s_tdata[34:3]);
                ad_reg  <= in_w(s_tdata[66:35]);
                bn_reg  <= in_w(s_tdata[98:67]);
                bd_reg  <= in_w(s_tdata[130:99]);
                rn_reg  <= '0;
                rd_reg  <= '0;
                gt_reg  <= 1'b0;
                lt_reg  <= 1'b0;
                eq_reg  <= 1'b0;
                err_reg <= 1'b0;
            end
            ST_MUL:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        if (step_reg == 2'd0)
                            p_reg <= mul_p;
                        else if (step_reg == 2'd1)
                        begin
                            x_reg <= (op_reg == OP_ADD) ? p_reg + mul_p : p_reg - mul_p;
                            n_reg <= (op_reg == OP_ADD) ? p_reg + mul_p : p_reg - mul_p;
                        end
                        else
                        begin
                            y_reg <= mul_p;
                            d_reg <= mul_p;
                        end
                    end
                    OP_MUL, OP_DIV:
                    begin
                        if (step_reg == 2'd0)
                        begin
                            x_reg <= mul_p;
                            n_reg <= mul_p;
                        end
                        else
                        begin
                            y_reg <= mul_p;
                            d_reg <= mul_p;
                        end
                    end
                    OP_RED:
                    begin
                        x_reg <= an_reg;
                        n_reg <= an_reg;
                        y_reg <= ad_reg;
                        d_reg <= ad_reg;
                    end
                    OP_ABS:
                    begin
                        rn_reg <= out_w(abs_w(an_reg));
                        rd_reg <= out_w(abs_w(ad_reg));
                    end
                    OP_CMP:
                    begin
                        if (step_reg == 2'd0)
                            p_reg <= mul_p;
                        else
                        begin
                            gt_reg <= $signed(p_reg) > $signed(mul_p);
                            lt_reg <= $signed(p_reg) < $signed(mul_p);
                            eq_reg <= p_reg == mul_p;
                        end
                    end
                    default: ;
                endcase
            end
            ST_GCD:
            begin
                if (waitq_reg && dctl.done)
                begin
                    x_reg <= y_reg;
                    y_reg <= drem;
                end
                else if (!waitq_reg && y_reg == '0)
                begin
                    y_reg   <= x_reg;
                    err_reg <= (x_reg == '0);
                end
            end
            ST_QN:
                if (waitq_reg && dctl.done)
                    rn_reg <= out_w(dquo);
            ST_QD:
                if (waitq_reg && dctl.done)
                    rd_reg <= out_w(dquo);
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, err_reg, eq_reg, lt_reg, gt_reg, rd_reg, rn_reg};

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && err_reg) |-> (rn_reg == '0 && rd_reg == '0))
        else $error("error result not zero");
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && op_reg == OP_CMP) |-> $onehot({gt_reg, lt_reg, eq_reg}))
        else $error("compare flags not one-hot");
`endif

endmodule

@@ sv/rau_divider.sv @@
// ----------------------------------------------------------------------------
// rau_divider
// Serial signed divider, one quotient bit per cycle, truncating like C.
// ----------------------------------------------------------------------------
module rau_divider #(
    parameter int W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         dividend,
    input  logic [W-1:0]         divisor,
    output rau_pkg::rau_div_ctl_t ctl,
    output logic [W-1:0]         quotient,
    output logic [W-1:0]         remainder
);
    import rau_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          qneg_reg;
    logic          rneg_reg;
    logic [W:0]    trial;
    logic [W-1:0]  shifted;

    assign shifted = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
            den_reg  <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
            qneg_reg <= dividend[W-1] ^ divisor[W-1];
            rneg_reg <= dividend[W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign quotient  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("start while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done longer than one cycle");
`endif

endmodule

@@ bench/rational_arith_unit_test.sv @@
// ----------------------------------------------------------------------------
// rational_arith_unit_test
// Drives fraction operations through the stream input and checks every result
// against a behavioral model of the unit, under varied idling and back-pressure.
// ----------------------------------------------------------------------------
module rational_arith_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2000;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic        div_error;
        logic        equal;
        logic        less;
        logic        greater;
        logic [31:0] res_den;
        logic [31:0] res_num;
    } frac_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    frac_result_t expected_results[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_off;
    int           error_count;
    int           items_sent;
    int           results_seen;
    int           idle_cycles;

    rational_arith_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] trunc_rem(logic [31:0] x, logic [31:0] y);
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] r;
        if (y == 0)
            return 0;
        mx = x[31] ? -x : x;
        my = y[31] ? -y : y;
        r = mx % my;
        return x[31] ? -r : r;
    endfunction

    function automatic logic [31:0] trunc_quot(logic [31:0] x, logic [31:0] y);
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] q;
        if (y == 0)
            return 0;
        mx = x[31] ? -x : x;
        my = y[31] ? -y : y;
        q = mx / my;
        return (x[31] != y[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] sat_abs(logic [31:0] v);
        if (!v[31])
            return v;
        if (v == INT_MIN)
            return INT_MAX;
        return -v;
    endfunction

    function automatic frac_result_t compute_fraction(logic [2:0] op,
            logic [31:0] an, logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
        frac_result_t r;
        logic [31:0] n;
        logic [31:0] d;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
        r = '0;
        n = 0;
        d = 0;
        case (op)
            OP_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
            OP_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
            OP_MUL: begin n = an * bn; d = ad * bd; end
            OP_DIV: begin n = an * bd; d = ad * bn; end
            OP_RED: begin n = an; d = ad; end
            OP_ABS:
            begin
                r.res_num = sat_abs(an);
                r.res_den = sat_abs(ad);
                return r;
            end
            OP_CMP:
            begin
                x = an * bd;
                y = ad * bn;
                r.greater = $signed(x) > $signed(y);
                r.less    = $signed(x) < $signed(y);
                r.equal   = x == y;
                return r;
            end
            default: return r;
        endcase
        x = n;
        y = d;
        while (y != 0)
        begin
            t = trunc_rem(x, y);
            x = y;
            y = t;
        end
        if (x == 0)
            r.div_error = 1'b1;
        else
        begin
            r.res_num = trunc_quot(n, x);
            r.res_den = trunc_quot(d, x);
        end
        return r;
    endfunction

    task automatic send_fraction(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
            logic [31:0] bn, logic [31:0] bd);
        while (!hold_off && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, bd, bn, ad, an, op};
        expected_results.push_back(compute_fraction(op, an, ad, bn, bd));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(40) - 20;
            1: return $urandom_range(1) ? INT_MIN : INT_MAX;
            2: return ($urandom_range(200) - 100) * (1 << $urandom_range(20));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_fraction(OP_ADD, 1, 2, 1, 3);
        send_fraction(OP_SUB, 1, 2, 1, 2);
        send_fraction(OP_MUL, -3, 4, 8, -9);
        send_fraction(OP_DIV, 2, 3, 4, 5);
        send_fraction(OP_MUL, 7, 1, -6, 1);
        send_fraction(OP_DIV, 7, 1, 0, 1);
        send_fraction(OP_RED, 0, 0, 5, 5);
        send_fraction(OP_RED, 12, -18, 0, 0);
        send_fraction(OP_RED, INT_MIN, -1, 0, 0);
        send_fraction(OP_RED, INT_MAX, INT_MIN, 0, 0);
        send_fraction(OP_RED, 0, 7, 0, 0);
        send_fraction(OP_ABS, INT_MIN, INT_MIN, 0, 0);
        send_fraction(OP_ABS, -5, INT_MAX, 0, 0);
        send_fraction(OP_CMP, 1, 2, 1, 3);
        send_fraction(OP_CMP, 1, 3, 1, 2);
        send_fraction(OP_CMP, 2, 4, 1, 2);
        send_fraction(OP_CMP, INT_MIN, INT_MAX, INT_MAX, INT_MIN);
        send_fraction(OP_NONE, 1, 2, 3, 4);
        send_fraction(OP_ADD, INT_MAX, INT_MAX, INT_MAX, INT_MAX);
        send_fraction(OP_SUB, INT_MIN, -1, INT_MIN, -1);
        send_fraction(OP_ADD, -1, -1, -1, -1);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic [2:0] op;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            op = 3'($urandom_range(7));
            if ($urandom_range(9) < 3)
                send_fraction(op, rand_word(), rand_word(), rand_word(), 1);
            else
                send_fraction(op, rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (6) send_fraction(OP_ABS, $urandom, $urandom, 0, 0);
        join
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        frac_result_t got;
        frac_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[67:0];
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.res_num !== want.res_num)
                begin
                    $error("res_num expected %h actual %h", want.res_num, got.res_num);
                    error_count++;
                end
                if (got.res_den !== want.res_den)
                begin
                    $error("res_den expected %h actual %h", want.res_den, got.res_den);
                    error_count++;
                end
                if (got.greater !== want.greater)
                begin
                    $error("greater expected %b actual %b", want.greater, got.greater);
                    error_count++;
                end
                if (got.less !== want.less)
                begin
                    $error("less expected %b actual %b", want.less, got.less);
                    error_count++;
                end
                if (got.equal !== want.equal)
                begin
                    $error("equal expected %b actual %b", want.equal, got.equal);
                    error_count++;
                end
                if (got.div_error !== want.div_error)
                begin
                    $error("div_error expected %b actual %b", want.div_error,
                        got.div_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rational_arith_unit");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(90, 0, 0);
        test_random(85, 74, 0);
        wait_drained();
        test_random(85, 0, 74);
        test_random(85, 37, 37);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d fraction operations, checked %0d results across", items_sent,
            results_seen);
        $display("all op codes, edge operands, idling mixes and a long output stall.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS rational_arith_unit");
        else
            $display("FAIL rational_arith_unit");
        $finish;
    end

endmodule
